>>> hw/rtl/mnp_pkg.sv
// Package for the MIDI note pairing block: sizes, codes and the structs
// shared by the controller, the datapath and the top level.
// Depends on nothing.
package mnp_pkg;

  localparam int PENDING_DEPTH = 64;
  localparam int IDX_W         = $clog2(PENDING_DEPTH);
  localparam int TIME_BITS     = 48;
  localparam int LEN_W         = 32;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_EN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_LEN = 1'd1;

  typedef enum logic [1:0] {
    ACT_NOTE_ON  = 2'd0,
    ACT_NOTE_OFF = 2'd1,
    ACT_OTHER    = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_PASS      = 2'd0,
    KIND_PAIRED    = 2'd1,
    KIND_UNMATCHED = 2'd2,
    KIND_OVERFLOW  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    LD_PASS_MID  = 2'd0,
    LD_PASS_LAST = 2'd1,
    LD_OVERFLOW  = 2'd2,
    LD_OFF_FINAL = 2'd3
  } load_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ON_SCAN,
    ST_OFF_PASS,
    ST_OFF_SCAN,
    ST_OFF_DRAIN,
    ST_OFF_FINAL,
    ST_EMIT_LAST
  } state_t;

  typedef struct packed {
    logic [7:0]           status;
    logic [6:0]           key;
    logic [6:0]           velocity;
    logic [TIME_BITS-1:0] on_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    action_t              action;
    logic [7:0]           status_byte;
    logic [6:0]           data_one;
    logic [6:0]           data_two;
    logic [TIME_BITS-1:0] event_time;
  } item_t;

  typedef struct packed {
    kind_t                result_kind;
    logic [7:0]           out_status;
    logic [6:0]           out_data_one;
    logic [6:0]           out_data_two;
    logic [TIME_BITS-1:0] first_time;
    logic [TIME_BITS-1:0] second_time;
    logic                 last_result;
  } res_t;

  typedef struct packed {
    logic      cap_item;
    logic      clear_all;
    logic      scan_rst;
    logic      scan_inc;
    logic      slot_write;
    logic      rd_issue;
    logic      out_load;
    load_sel_t load_sel;
    logic      drop_best;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t action;
    logic    slot_busy;
    logic    scan_last;
    logic    out_free;
  } ctrl_stat_t;

endpackage

>>> hw/rtl/mnp_if.sv
// Request and result channel interfaces of the MIDI note pairing block.
// Depends on mnp_pkg for the time width.
interface mnp_in_if import mnp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [7:0]           status_byte;
  logic [6:0]           data_one;
  logic [6:0]           data_two;
  logic [TIME_BITS-1:0] event_time;

  modport source (output valid, action, status_byte, data_one, data_two, event_time,
                  input ready);
  modport sink   (input valid, action, status_byte, data_one, data_two, event_time,
                  output ready);
endinterface

interface mnp_out_if import mnp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           result_kind;
  logic [7:0]           out_status;
  logic [6:0]           out_data_one;
  logic [6:0]           out_data_two;
  logic [TIME_BITS-1:0] first_time;
  logic [TIME_BITS-1:0] second_time;
  logic                 last_result;

  modport source (output valid, result_kind, out_status, out_data_one, out_data_two,
                  first_time, second_time, last_result, input ready);
  modport sink   (input valid, result_kind, out_status, out_data_one, out_data_two,
                  first_time, second_time, last_result, output ready);
endinterface

>>> hw/rtl/mnp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/mnp_ctrl.sv
// Controller of the MIDI note pairing block: sequences table scans and
// result emission. Depends on mnp_pkg.
module mnp_ctrl import mnp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  action_t    in_action,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.load_sel = LD_PASS_LAST;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_item = 1'b1;
          cmd.scan_rst = 1'b1;
          unique case (in_action)
            ACT_NOTE_ON:  state_nxt = ST_ON_SCAN;
            ACT_NOTE_OFF: state_nxt = ST_OFF_PASS;
            ACT_OTHER:    state_nxt = ST_EMIT_LAST;
            ACT_CLEAR:    cmd.clear_all = 1'b1;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ON_SCAN: begin
        if (!stat.slot_busy) begin
          cmd.slot_write = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (stat.scan_last) begin
          state_nxt = ST_EMIT_LAST;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      ST_OFF_PASS: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.load_sel = LD_PASS_MID;
          state_nxt    = ST_OFF_SCAN;
        end
      end
      ST_OFF_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_OFF_DRAIN;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      ST_OFF_DRAIN: begin
        state_nxt = ST_OFF_FINAL;
      end
      ST_OFF_FINAL: begin
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.load_sel  = LD_OFF_FINAL;
          cmd.drop_best = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_EMIT_LAST: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.load_sel = (stat.action == ACT_NOTE_ON) ? LD_OVERFLOW : LD_PASS_LAST;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/mnp_dp.sv
// Datapath of the MIDI note pairing block: item and config registers, the
// pending table with its valid bits, the nearest-match search and the result
// register. Depends on mnp_pkg and mnp_ram.
module mnp_dp import mnp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  item_t                 in_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  ctrl_cmd_t             cmd,
  output ctrl_stat_t            stat,
  output res_t                  res,
  output logic                  res_valid,
  input  logic                  res_ready
);

  item_t                item_r;
  logic                 fixed_en_r;
  logic [LEN_W-1:0]     fixed_len_r;
  logic [PENDING_DEPTH-1:0] valid_r;
  logic [IDX_W-1:0]     cnt_r;
  logic                 rd_act_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 best_found_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [TIME_BITS-1:0] best_dist_r;
  entry_t               best_entry_r;
  res_t                 out_r, out_nxt;
  logic                 out_valid_r;

  entry_t               rd_entry;
  entry_t               wr_entry;
  logic [TIME_BITS:0]   diff;
  logic                 cand;
  logic                 better;
  logic                 out_free;
  logic [TIME_BITS-1:0] off_time;

  assign wr_entry = '{status:   item_r.status_byte,
                      key:      item_r.data_one,
                      velocity: item_r.data_two,
                      on_time:  item_r.event_time};

  mnp_ram #(.WIDTH(ENTRY_W), .DEPTH(PENDING_DEPTH)) u_table (
    .clk   (clk),
    .we    (cmd.slot_write),
    .waddr (cnt_r),
    .wdata (wr_entry),
    .raddr (cnt_r),
    .rdata (rd_entry)
  );

  // The borrow of the distance subtraction tells whether the note-on is later.
  assign diff   = {1'b0, item_r.event_time} - {1'b0, rd_entry.on_time};
  assign cand   = rd_act_r && valid_r[rd_idx_r] && (rd_entry.key == item_r.data_one)
                  && !diff[TIME_BITS];
  assign better = !best_found_r || (diff[TIME_BITS-1:0] < best_dist_r);

  assign out_free = !out_valid_r || res_ready;

  assign off_time = (fixed_en_r && (fixed_len_r != '0))
                    ? best_entry_r.on_time + TIME_BITS'(fixed_len_r)
                    : item_r.event_time;

  always_comb begin
    out_nxt.result_kind  = KIND_PASS;
    out_nxt.out_status   = item_r.status_byte;
    out_nxt.out_data_one = item_r.data_one;
    out_nxt.out_data_two = item_r.data_two;
    out_nxt.first_time   = item_r.event_time;
    out_nxt.second_time  = '0;
    out_nxt.last_result  = 1'b1;
    unique case (cmd.load_sel)
      LD_PASS_MID:  out_nxt.last_result = 1'b0;
      LD_PASS_LAST: out_nxt.result_kind = KIND_PASS;
      LD_OVERFLOW:  out_nxt.result_kind = KIND_OVERFLOW;
      LD_OFF_FINAL: begin
        if (best_found_r) begin
          out_nxt.result_kind  = KIND_PAIRED;
          out_nxt.out_status   = best_entry_r.status;
          out_nxt.out_data_one = best_entry_r.key;
          out_nxt.out_data_two = best_entry_r.velocity;
          out_nxt.first_time   = best_entry_r.on_time;
          out_nxt.second_time  = off_time;
        end else begin
          out_nxt.result_kind = KIND_UNMATCHED;
        end
      end
      default: out_nxt.result_kind = KIND_PASS;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_en_r   <= 1'b0;
      fixed_len_r  <= '0;
      valid_r      <= '0;
      rd_act_r     <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_FIXED_EN) begin
        fixed_en_r <= cfg_wdata[0];
      end
      if (cfg_we && cfg_index == CFG_FIXED_LEN) begin
        fixed_len_r <= cfg_wdata[LEN_W-1:0];
      end
      if (cmd.clear_all) begin
        valid_r <= '0;
      end else if (cmd.slot_write) begin
        valid_r[cnt_r] <= 1'b1;
      end else if (cmd.drop_best && best_found_r) begin
        valid_r[best_idx_r] <= 1'b0;
      end
      rd_act_r <= cmd.rd_issue;
      if (cmd.scan_rst) begin
        best_found_r <= 1'b0;
      end else if (cand && better) begin
        best_found_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and counters.
  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      item_r <= in_item;
    end
    if (cmd.scan_rst) begin
      cnt_r <= '0;
    end else if (cmd.scan_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
    rd_idx_r <= cnt_r;
    if (cand && better) begin
      best_idx_r   <= rd_idx_r;
      best_dist_r  <= diff[TIME_BITS-1:0];
      best_entry_r <= rd_entry;
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign stat.action    = item_r.action;
  assign stat.slot_busy = valid_r[cnt_r];
  assign stat.scan_last = (cnt_r == IDX_W'(PENDING_DEPTH - 1));
  assign stat.out_free  = out_free;

  assign res       = out_r;
  assign res_valid = out_valid_r;

endmodule

>>> hw/rtl/midi_note_pairing.sv
// Top level of the MIDI note pairing block: request and result channels,
// configuration port. Depends on mnp_pkg, mnp_if, mnp_ctrl, mnp_dp, mnp_ram.
//
// Usage. Recorded MIDI events arrive on in_req, one request per event, and
// are taken when valid and ready are both high. A note-on is parked in a
// pending table of PENDING_DEPTH entries and gives no result unless the
// table is full, in which case one overflow result comes out. Any other event
// gives one pass result. A note-off gives a pass result followed by a paired
// note or an unmatched result; last_result marks the final result of each
// request. A clear request empties the table with no result. The block
// serves one request at a time and takes the next only back in idle. A
// note-on runs a linear search of the valid bits for the lowest free entry
// (an overflow result when none is free), and a note-off a scan that reads
// one table entry per cycle from the single RAM read port. A pass result is
// loaded into the output register ahead of any search, the others at the
// end of the search. A result waits in the output register while the
// receiver stalls; the block holds only once it has the next result to
// load, and then takes no request. Reset (rst_n low, synchronous) empties
// the table, clears both registers and the output valid bit; the table
// itself needs no clearing pass. Configuration (cfg_we, cfg_index, cfg_wdata)
// is to be written by the user only while idle; the block has no check for it.
module midi_note_pairing import mnp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mnp_in_if.sink                in_req,
  mnp_out_if.source             out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  item_t      in_item;
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  res_t       res;
  logic       res_valid;

  assign in_item = '{action:      action_t'(in_req.action),
                     status_byte: in_req.status_byte,
                     data_one:    in_req.data_one,
                     data_two:    in_req.data_two,
                     event_time:  in_req.event_time};

  mnp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_action (in_item.action),
    .in_ready  (in_req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mnp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (out_res.ready)
  );

  // The result register drives the channel directly.
  assign out_res.valid        = res_valid;
  assign out_res.result_kind  = res.result_kind;
  assign out_res.out_status   = res.out_status;
  assign out_res.out_data_one = res.out_data_one;
  assign out_res.out_data_two = res.out_data_two;
  assign out_res.first_time   = res.first_time;
  assign out_res.second_time  = res.second_time;
  assign out_res.last_result  = res.last_result;

endmodule

>>> tb/midi_note_pairing_tb.sv
// Self-checking testbench for the MIDI note pairing block: directed and random requests
// checked against a behavioral model of the pending table kept in a small class.
// Depends on mnp_pkg, mnp_if and the midi_note_pairing RTL.
module midi_note_pairing_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mnp_pkg::*;

  localparam int                   CYCLE_LIMIT = 1_000_000;
  localparam logic [TIME_BITS-1:0] TIME_TOP    = '1;

  // Behavioral copy of the pending table and the length registers. Every accepted
  // request is applied here in order, and the results it must cause are queued.
  class pairing_ledger;
    bit             slot_used [PENDING_DEPTH];
    entry_t         slot_note [PENDING_DEPTH];
    bit             fixed_en;
    bit [LEN_W-1:0] fixed_len;
    res_t           owed_results [$];
    int             errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      fixed_en  = 1'b0;
      fixed_len = '0;
      errors    = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_FIXED_EN:  fixed_en  = value[0];
        CFG_FIXED_LEN: fixed_len = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // A result that repeats the request's own fields, as pass, unmatched and
    // overflow results do.
    function res_t echo_of(kind_t kind, item_t req, bit last);
      res_t r;
      r.result_kind  = kind;
      r.out_status   = req.status_byte;
      r.out_data_one = req.data_one;
      r.out_data_two = req.data_two;
      r.first_time   = req.event_time;
      r.second_time  = '0;
      r.last_result  = last;
      return r;
    endfunction

    function void take_request(item_t req);
      int                   free_slot;
      int                   best;
      logic [TIME_BITS-1:0] gap;
      logic [TIME_BITS-1:0] best_gap;
      res_t                 paired;
      free_slot = -1;
      best      = -1;
      best_gap  = '0;
      case (req.action)
        ACT_NOTE_ON: begin
          for (int i = 0; i < PENDING_DEPTH && free_slot < 0; i++)
            if (!slot_used[i]) free_slot = i;
          if (free_slot < 0) begin
            owed_results = {owed_results, echo_of(KIND_OVERFLOW, req, 1'b1)};
          end else begin
            slot_used[free_slot] = 1'b1;
            slot_note[free_slot] = '{status: req.status_byte, key: req.data_one,
                                     velocity: req.data_two, on_time: req.event_time};
          end
        end
        ACT_OTHER: begin
          owed_results = {owed_results, echo_of(KIND_PASS, req, 1'b1)};
        end
        ACT_CLEAR: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
        end
        default: begin
          owed_results = {owed_results, echo_of(KIND_PASS, req, 1'b0)};
          for (int i = 0; i < PENDING_DEPTH; i++) begin
            if (slot_used[i] && slot_note[i].key == req.data_one &&
                slot_note[i].on_time <= req.event_time) begin
              gap = req.event_time - slot_note[i].on_time;
              // Strict compare keeps the lowest index on a tie.
              if (best < 0 || gap < best_gap) begin
                best     = i;
                best_gap = gap;
              end
            end
          end
          if (best < 0) begin
            owed_results = {owed_results, echo_of(KIND_UNMATCHED, req, 1'b1)};
          end else begin
            paired.result_kind  = KIND_PAIRED;
            paired.out_status   = slot_note[best].status;
            paired.out_data_one = slot_note[best].key;
            paired.out_data_two = slot_note[best].velocity;
            paired.first_time   = slot_note[best].on_time;
            paired.second_time  = (fixed_en && fixed_len != 0) ?
                                  slot_note[best].on_time + TIME_BITS'(fixed_len) :
                                  req.event_time;
            paired.last_result  = 1'b1;
            slot_used[best] = 1'b0;
            owed_results = {owed_results, paired};
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want_v, logic [63:0] got_v);
      if (got_v !== want_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void match_result(res_t got);
      res_t want;
      if (owed_results.size() == 0) begin
        $error("result with nothing expected: kind %0d first_time %0h",
               got.result_kind, got.first_time);
        errors++;
        return;
      end
      want = owed_results[0];
      owed_results.delete(0);
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("out_status", want.out_status, got.out_status);
      compare_field("out_data_one", want.out_data_one, got.out_data_one);
      compare_field("out_data_two", want.out_data_two, got.out_data_two);
      compare_field("first_time", want.first_time, got.first_time);
      compare_field("second_time", want.second_time, got.second_time);
      compare_field("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mnp_in_if  in_req ();
  mnp_out_if out_res ();

  pairing_ledger        board = new();
  int                   send_idle_pct;
  int                   recv_stall_pct;
  int                   requests_sent;
  int                   cycle_count;
  logic [TIME_BITS-1:0] clock_us;

  midi_note_pairing u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Result side. Ready is redrawn every cycle from the current stall rate, and
  // valid/ready are sampled as they stood just before the edge, so a result is
  // checked exactly at the edge that takes it.
  initial out_res.ready = 1'b0;

  always @(posedge clk) begin
    res_t got;
    out_res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && out_res.valid && out_res.ready) begin
      got.result_kind  = kind_t'(out_res.result_kind);
      got.out_status   = out_res.out_status;
      got.out_data_one = out_res.out_data_one;
      got.out_data_two = out_res.out_data_two;
      got.first_time   = out_res.first_time;
      got.second_time  = out_res.second_time;
      got.last_result  = out_res.last_result;
      board.match_result(got);
    end
  end

  // Watchdog: a run that stalls or loses a result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("midi_note_pairing verification failed");
      $finish;
    end
  end

  // Offers one request, with a random number of idle cycles ahead of it, and
  // holds it until the block takes it. Valid is left high on return so that
  // back-to-back requests keep it up without a dip.
  task automatic send_request(input action_t act, input logic [7:0] st,
                              input logic [6:0] d1, input logic [6:0] d2,
                              input logic [TIME_BITS-1:0] t);
    item_t req;
    req = '{action: act, status_byte: st, data_one: d1, data_two: d2, event_time: t};
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.action      <= act;
    in_req.status_byte <= st;
    in_req.data_one    <= d1;
    in_req.data_two    <= d2;
    in_req.event_time  <= t;
    do @(posedge clk); while (!in_req.ready);
    board.take_request(req);
    requests_sent++;
  endtask

  // Holds the request side off until every owed result has come back. A note-on
  // has no result yet may still be searching the table, so a full note-off
  // latency is allowed on top before the block counts as idle.
  task automatic settle_block();
    in_req.valid <= 1'b0;
    while (board.owed_results.size() != 0) @(posedge clk);
    repeat (PENDING_DEPTH + 8) @(posedge clk);
  endtask

  // Writes both length registers, the enable one first. The enable word
  // carries random upper bits, which the block must ignore.
  task automatic program_length(input bit en, input logic [LEN_W-1:0] len);
    logic [CFG_DATA_W-1:0] en_word;
    en_word    = $urandom;
    en_word[0] = en;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIXED_EN;
    cfg_wdata <= en_word;
    @(posedge clk);
    cfg_index <= CFG_FIXED_LEN;
    cfg_wdata <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_register(CFG_FIXED_EN, en_word);
    board.write_register(CFG_FIXED_LEN, CFG_DATA_W'(len));
  endtask

  function automatic logic [TIME_BITS-1:0] any_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  task automatic run_directed();
    // Field extremes on pass-through events; the status byte does not matter.
    send_request(ACT_OTHER, 8'h00, 7'h00, 7'h00, '0);
    send_request(ACT_OTHER, 8'hFF, 7'h7F, 7'h7F, TIME_TOP);
    send_request(ACT_OTHER, 8'h90, 7'd64, 7'd100, 48'd50);
    // A note-off against an empty table gives a pass and an unmatched result.
    send_request(ACT_NOTE_OFF, 8'h80, 7'd5, 7'd64, 48'd100);
    // Velocity zero parks like any other note-on.
    send_request(ACT_NOTE_ON, 8'h90, 7'd10, 7'd0, 48'd100);
    send_request(ACT_NOTE_ON, 8'h91, 7'd10, 7'd50, 48'd200);
    send_request(ACT_NOTE_ON, 8'h92, 7'd10, 7'd60, 48'd200);
    // Only the first note-on is not later than this note-off.
    send_request(ACT_NOTE_OFF, 8'h80, 7'd10, 7'd0, 48'd150);
    // Two candidates at the same distance: the lower table entry goes first.
    send_request(ACT_NOTE_OFF, 8'h80, 7'd10, 7'd0, 48'd300);
    send_request(ACT_NOTE_OFF, 8'h80, 7'd10, 7'd0, 48'd300);
    // A note-on later than the note-off is no candidate.
    send_request(ACT_NOTE_ON, 8'h93, 7'd20, 7'd1, 48'd500);
    send_request(ACT_NOTE_OFF, 8'h83, 7'd20, 7'd1, 48'd400);
    // Clearing drops the parked note, so the later note-off finds nothing.
    send_request(ACT_CLEAR, 8'hA5, 7'h55, 7'h2A, 48'd550);
    send_request(ACT_NOTE_OFF, 8'h83, 7'd20, 7'd1, 48'd600);
    // Zero distance at the top of the time range.
    send_request(ACT_NOTE_ON, 8'h9F, 7'h7F, 7'h7F, TIME_TOP);
    send_request(ACT_NOTE_OFF, 8'h8F, 7'h7F, 7'h7F, TIME_TOP);
    settle_block();
    // Fixed length whose end time wraps past the top of the time range.
    program_length(1'b1, 32'h100);
    send_request(ACT_NOTE_ON, 8'h90, 7'd1, 7'd100, TIME_TOP - 48'h10);
    send_request(ACT_NOTE_OFF, 8'h80, 7'd1, 7'd0, TIME_TOP);
    settle_block();
    // Enabled with a zero length: the note-off keeps its own time.
    program_length(1'b1, '0);
    send_request(ACT_NOTE_ON, 8'h90, 7'd2, 7'd90, 48'd1000);
    send_request(ACT_NOTE_OFF, 8'h80, 7'd2, 7'd0, 48'd1500);
    settle_block();
    program_length(1'b1, '1);
    send_request(ACT_NOTE_ON, 8'h90, 7'd3, 7'd80, 48'd2000);
    send_request(ACT_NOTE_OFF, 8'h80, 7'd3, 7'd0, 48'd2100);
  endtask

  // A short musical phrase: a few note-ons on a narrow key range, some stacked
  // at one time, then their note-offs in shuffled order. A few note-offs are
  // dropped so that notes hang in the table and later matches see stale entries.
  task automatic play_phrase();
    logic [6:0] keys [$];
    logic [3:0] chan;
    logic [6:0] k;
    int         n;
    int         pick;
    n    = $urandom_range(1, 6);
    chan = 4'($urandom);
    for (int i = 0; i < n; i++) begin
      k = 7'd60 + 7'($urandom_range(0, 5));
      keys = {keys, k};
      send_request(ACT_NOTE_ON, {4'h9, chan}, k, 7'($urandom), clock_us);
      clock_us += $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0)
        send_request(ACT_OTHER, {4'hB, chan}, 7'($urandom), 7'($urandom), clock_us);
    end
    while (keys.size() != 0) begin
      clock_us += $urandom_range(0, 50);
      pick = $urandom_range(0, keys.size() - 1);
      if ($urandom_range(0, 9) != 0)
        send_request(ACT_NOTE_OFF, {4'h8, chan}, keys[pick], 7'($urandom), clock_us);
      keys.delete(pick);
    end
  endtask

  // A broken order: the note-off arrives before its note-on and misses, and a
  // second note-off then picks the note up.
  task automatic play_late_release();
    logic [6:0] k;
    k = 7'($urandom);
    send_request(ACT_NOTE_OFF, 8'h80, k, 7'($urandom), clock_us);
    clock_us += $urandom_range(1, 20);
    send_request(ACT_NOTE_ON, 8'h90, k, 7'($urandom), clock_us);
    clock_us += $urandom_range(0, 20);
    send_request(ACT_NOTE_OFF, 8'h80, k, 7'($urandom), clock_us);
  endtask

  task automatic play_noise();
    send_request(action_t'($urandom_range(0, 3)), 8'($urandom), 7'($urandom),
                 7'($urandom), any_time());
  endtask

  // Fills every table entry and pushes a few note-ons past it to cause
  // overflow results, then waits with the request side quiet until all of them
  // are back, and releases some notes against the full table.
  task automatic flood_table();
    int extra;
    send_request(ACT_CLEAR, 8'($urandom), 7'($urandom), 7'($urandom), clock_us);
    extra = $urandom_range(1, 4);
    for (int i = 0; i < PENDING_DEPTH + extra; i++) begin
      send_request(ACT_NOTE_ON, 8'h90 | 8'($urandom_range(0, 15)), 7'($urandom),
                   7'($urandom), clock_us);
      clock_us += $urandom_range(0, 2);
    end
    settle_block();
    for (int i = 0; i < 8; i++) begin
      clock_us += $urandom_range(0, 30);
      send_request(ACT_NOTE_OFF, 8'h80, 7'($urandom), 7'($urandom), clock_us);
    end
  endtask

  // One random phase. Mostly well-formed phrases; the rest is noise, stray
  // events, clears, pauses until the block is drained, and now and then a flood.
  task automatic run_phase(input int send_pct, input int stall_pct, input int quota,
                           input bit open_with_flood);
    int target;
    int pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    target         = requests_sent + quota;
    if (open_with_flood) flood_table();
    while (requests_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        play_phrase();
      end else if (pick < 65) begin
        play_late_release();
      end else if (pick < 75) begin
        send_request(ACT_OTHER, 8'($urandom), 7'($urandom), 7'($urandom), clock_us);
        clock_us += $urandom_range(0, 10);
      end else if (pick < 90) begin
        play_noise();
      end else if (pick < 95) begin
        send_request(ACT_CLEAR, 8'($urandom), 7'($urandom), 7'($urandom), clock_us);
      end else if (pick < 98) begin
        settle_block();
      end else begin
        flood_table();
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_req.valid       = 1'b0;
    in_req.action      = ACT_OTHER;
    in_req.status_byte = '0;
    in_req.data_one    = '0;
    in_req.data_two    = '0;
    in_req.event_time  = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    requests_sent      = 0;
    cycle_count        = 0;
    clock_us           = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values written explicitly, then the directed requests.
    program_length(1'b0, '0);
    run_directed();

    // Phase one: length disabled but nonzero, so it must have no effect.
    settle_block();
    program_length(1'b0, LEN_W'($urandom));
    clock_us = 48'd10_000;
    run_phase(6, 46, 150, 1'b1);

    // Phase two: short fixed lengths.
    settle_block();
    program_length(1'b1, LEN_W'($urandom_range(1, 2000)));
    run_phase(46, 6, 150, 1'b0);

    // Phase three: any length, with event times near the top of the
    // range so that the fixed-length sums wrap.
    settle_block();
    program_length(1'b1, LEN_W'($urandom));
    send_request(ACT_CLEAR, 8'h00, 7'h00, 7'h00, '0);
    clock_us = TIME_TOP - 48'd20_000;
    run_phase(0, 0, 150, 1'b0);

    settle_block();
    if (board.errors == 0) begin
      $display("midi_note_pairing verification clean");
    end else begin
      $display("midi_note_pairing verification failed");
    end
    $finish;
  end

endmodule
